### rtl/core/nv12_to_rgb_nearest_scaler_assert.svh
// ----------------------------------------------------------------------------
// NV12 scaler assertion macros
// Concurrent checks for the scaler core, compiled out under synthesis.
// ----------------------------------------------------------------------------
`ifndef NV12_TO_RGB_NEAREST_SCALER_ASSERT_SVH
`define NV12_TO_RGB_NEAREST_SCALER_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property under reset gating.
`define NVS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nv12 scaler check failed");
// Same-cycle implication.
`define NVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nv12 scaler check failed");
// Next-cycle implication.
`define NVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nv12 scaler check failed");
`else
`define NVS_ASSERT(label, clk, rst_n, prop)
`define NVS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/nv12s_pkg.sv
// ----------------------------------------------------------------------------
// NV12 scaler package
// Register map, reset values, BT.601 coefficients and the output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nv12s_pkg;

  localparam int CfgW    = 13;
  localparam int CfgIdxW = 3;
  localparam int PixW    = 8;
  localparam int SumW    = 20;

  typedef enum logic [CfgIdxW-1:0] {
    RegSrcW = 3'd0,
    RegSrcH = 3'd1,
    RegDstW = 3'd2,
    RegDstH = 3'd3
  } cfg_reg_e;

  localparam logic [CfgW-1:0] SrcWReset = 13'd3840;
  localparam logic [CfgW-1:0] SrcHReset = 13'd2160;
  localparam logic [CfgW-1:0] DstWReset = 13'd640;
  localparam logic [CfgW-1:0] DstHReset = 13'd640;

  // BT.601 limited range, 8 fractional bits
  localparam logic signed [SumW-1:0] CoefY    = 20'sd298;
  localparam logic signed [SumW-1:0] CoefRV   = 20'sd409;
  localparam logic signed [SumW-1:0] CoefGU   = 20'sd100;
  localparam logic signed [SumW-1:0] CoefGV   = 20'sd208;
  localparam logic signed [SumW-1:0] CoefBU   = 20'sd516;
  localparam logic signed [SumW-1:0] RoundAdd = 20'sd128;
  localparam logic [9:0]             LumaOfs  = 10'd16;
  localparam logic [9:0]             ChromaOfs = 10'd128;
  localparam logic signed [SumW-1:0] PixMax   = 20'sd255;

  // Floor-divide by 256 and clamp to 0..255.
  function automatic logic [PixW-1:0] scale_clamp(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] q;
    q = v >>> 8;
    if (q < 0) begin
      scale_clamp = '0;
    end else if (q > PixMax) begin
      scale_clamp = '1;
    end else begin
      scale_clamp = q[PixW-1:0];
    end
  endfunction

endpackage

### rtl/core/nv12_to_rgb_nearest_scaler.sv
// Path: a kept pixel passes the input register, then the result register.
// Throughput: one source pixel per cycle unless stalled; the keep test and the
// counter update settle at accept, the color math in the next register stage.
// Reset: registers return to their defaults and all counters and accumulators
// clear at once; no clearing pass. Any register write restarts the frame.
// ----------------------------------------------------------------------------
// NV12 to RGB nearest-neighbor downscaler
// Picks source pixels by exact integer stepping and converts them to RGB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nv12_to_rgb_nearest_scaler_assert.svh"

module nv12_to_rgb_nearest_scaler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nv12s_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [nv12s_pkg::CfgW-1:0]      cfg_data_i,
  // source pixels
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      luma_i,
  input  logic [7:0]                      chroma_blue_i,
  input  logic [7:0]                      chroma_red_i,
  // RGB pixels
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic                            frame_end_o
);

  localparam int CfgW = nv12s_pkg::CfgW;
  localparam int EW   = CfgW + 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int AWX  = 2 * WW;
  localparam int AWY  = 2 * HW;
  localparam logic [EW-1:0] MaxW = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MaxH = EW'(MAX_HEIGHT);
  localparam logic [EW-1:0] One  = EW'(1);

  // configuration registers
  logic [CfgW-1:0] source_width_q, source_height_q, target_width_q, target_height_q;
  logic            cfg_we, cfg_hit;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    case (cfg_index_i)
      nv12s_pkg::RegSrcW: cfg_hit = 1'b1;
      nv12s_pkg::RegSrcH: cfg_hit = 1'b1;
      nv12s_pkg::RegDstW: cfg_hit = 1'b1;
      nv12s_pkg::RegDstH: cfg_hit = 1'b1;
      default:            cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_width_q  <= nv12s_pkg::SrcWReset;
      source_height_q <= nv12s_pkg::SrcHReset;
      target_width_q  <= nv12s_pkg::DstWReset;
      target_height_q <= nv12s_pkg::DstHReset;
    end else if (cfg_we) begin
      case (cfg_index_i)
        nv12s_pkg::RegSrcW: source_width_q  <= cfg_data_i;
        nv12s_pkg::RegSrcH: source_height_q <= cfg_data_i;
        nv12s_pkg::RegDstW: target_width_q  <= cfg_data_i;
        nv12s_pkg::RegDstH: target_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes: zero counts as one, targets never exceed sources
  logic [EW-1:0] sw_ext, sh_ext, tw_ext, th_ext;
  logic [EW-1:0] sw_full, sh_full, tw_full, th_full;
  logic [WW-1:0] sw, tw;
  logic [HW-1:0] sh, th;

  always_comb begin
    sw_ext = {1'b0, source_width_q};
    sh_ext = {1'b0, source_height_q};
    tw_ext = {1'b0, target_width_q};
    th_ext = {1'b0, target_height_q};
    sw_full = (sw_ext == '0) ? One : ((sw_ext > MaxW) ? MaxW : sw_ext);
    sh_full = (sh_ext == '0) ? One : ((sh_ext > MaxH) ? MaxH : sh_ext);
    tw_full = (tw_ext == '0) ? One : ((tw_ext > sw_full) ? sw_full : tw_ext);
    th_full = (th_ext == '0) ? One : ((th_ext > sh_full) ? sh_full : th_ext);
    sw = sw_full[WW-1:0];
    sh = sh_full[HW-1:0];
    tw = tw_full[WW-1:0];
    th = th_full[HW-1:0];
  end

  // handshake
  logic out_valid_q, s1_valid_q;
  logic out_adv, s1_free, in_acc;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // pick counters; the base accumulators hold src_col*TW and src_row*TH
  logic [XW-1:0]  src_col_q, src_col_d;
  logic [YW-1:0]  src_row_q, src_row_d;
  logic [WW-1:0]  out_col_q, out_col_d;
  logic [HW-1:0]  out_row_q, out_row_d;
  logic [AWX-1:0] col_pick_q, col_pick_d, col_base_q, col_base_d, col_bound;
  logic [AWY-1:0] row_pick_q, row_pick_d, row_base_q, row_base_d, row_bound;
  logic [WW-1:0]  src_col_inc, out_col_inc;
  logic [HW-1:0]  src_row_inc, out_row_inc;
  logic           col_hit, row_hit, keep, last_pix;

  always_comb begin
    col_bound   = col_base_q + AWX'(tw);
    row_bound   = row_base_q + AWY'(th);
    col_hit     = (out_col_q < tw) && (col_pick_q < col_bound);
    row_hit     = (out_row_q < th) && (row_pick_q < row_bound);
    keep        = col_hit && row_hit;
    src_col_inc = WW'(src_col_q) + WW'(1);
    src_row_inc = HW'(src_row_q) + HW'(1);
    out_col_inc = out_col_q + WW'(1);
    out_row_inc = out_row_q + HW'(1);
    last_pix    = (out_col_inc == tw) && (out_row_inc == th);

    src_col_d  = src_col_q;
    src_row_d  = src_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    col_pick_d = col_pick_q;
    col_base_d = col_base_q;
    row_pick_d = row_pick_q;
    row_base_d = row_base_q;

    if (cfg_we && cfg_hit) begin
      src_col_d  = '0;
      src_row_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      col_pick_d = '0;
      col_base_d = '0;
      row_pick_d = '0;
      row_base_d = '0;
    end else if (in_acc) begin
      if (col_hit) begin
        out_col_d  = out_col_inc;
        col_pick_d = col_pick_q + AWX'(sw);
      end
      col_base_d = col_base_q + AWX'(tw);
      if (src_col_inc >= sw) begin
        // end of line: restart column state, step the row
        src_col_d  = '0;
        out_col_d  = '0;
        col_pick_d = '0;
        col_base_d = '0;
        if (row_hit) begin
          out_row_d  = out_row_inc;
          row_pick_d = row_pick_q + AWY'(sh);
        end
        row_base_d = row_base_q + AWY'(th);
        if (src_row_inc >= sh) begin
          src_row_d  = '0;
          out_row_d  = '0;
          row_pick_d = '0;
          row_base_d = '0;
        end else begin
          src_row_d = src_row_inc[YW-1:0];
        end
      end else begin
        src_col_d = src_col_inc[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q  <= '0;
      src_row_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      col_pick_q <= '0;
      col_base_q <= '0;
      row_pick_q <= '0;
      row_base_q <= '0;
    end else begin
      src_col_q  <= src_col_d;
      src_row_q  <= src_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      col_pick_q <= col_pick_d;
      col_base_q <= col_base_d;
      row_pick_q <= row_pick_d;
      row_base_q <= row_base_d;
    end
  end

  // input register: kept pixels only
  logic [7:0] y_q, u_q, v_q;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_acc && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_acc && keep) begin
      y_q    <= luma_i;
      u_q    <= chroma_blue_i;
      v_q    <= chroma_red_i;
      last_q <= last_pix;
    end
  end

  // color conversion
  logic signed [nv12s_pkg::SumW-1:0] c_s, d_s, e_s, r_sum, g_sum, b_sum;

  always_comb begin
    c_s   = nv12s_pkg::SumW'($signed({2'b00, y_q} - nv12s_pkg::LumaOfs));
    d_s   = nv12s_pkg::SumW'($signed({2'b00, u_q} - nv12s_pkg::ChromaOfs));
    e_s   = nv12s_pkg::SumW'($signed({2'b00, v_q} - nv12s_pkg::ChromaOfs));
    r_sum = nv12s_pkg::CoefY * c_s + nv12s_pkg::CoefRV * e_s + nv12s_pkg::RoundAdd;
    g_sum = nv12s_pkg::CoefY * c_s - nv12s_pkg::CoefGU * d_s - nv12s_pkg::CoefGV * e_s
            + nv12s_pkg::RoundAdd;
    b_sum = nv12s_pkg::CoefY * c_s + nv12s_pkg::CoefBU * d_s + nv12s_pkg::RoundAdd;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      red_o       <= nv12s_pkg::scale_clamp(r_sum);
      green_o     <= nv12s_pkg::scale_clamp(g_sum);
      blue_o      <= nv12s_pkg::scale_clamp(b_sum);
      frame_end_o <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `NVS_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, s1_valid_q && out_valid_q)
  `NVS_ASSERT_NEXT(a_cfg_restarts, clk_i, rst_ni, cfg_we && cfg_hit, src_col_q == '0 && out_row_q == '0)
  `NVS_ASSERT(a_out_col_bounded, clk_i, rst_ni, out_col_q <= tw)

endmodule
